>>> rtl/core/aoi_pkg.sv
// ----------------------------------------------------------------------------
// aoi_pkg
// Shared types, codes and reset values for the threshold contention block.
// ----------------------------------------------------------------------------
`default_nettype none

package aoi_pkg;

   // default sizes
   localparam int DEVICES_DEFAULT  = 10;
   localparam int AGE_BITS_DEFAULT = 24;
   localparam int SUM_BITS_DEFAULT = 48;

   // fixed field widths
   localparam int THR_BITS       = 24;
   localparam int LIMIT_BITS     = 31;
   localparam int GEN_BITS       = 31;
   localparam int MUL_BITS       = 15;
   localparam int PROD_BITS      = GEN_BITS + MUL_BITS;
   localparam int READ_SUM_BITS  = 48;
   localparam int READ_AGE_BITS  = 24;
   localparam int DEV_IDX_BITS   = 4;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 31;

   // lehmer generator constants
   localparam logic [MUL_BITS-1:0] LEHMER_MUL = 15'd16807;
   localparam logic [GEN_BITS-1:0] LEHMER_MOD = 31'h7FFF_FFFF;

   // register reset values
   localparam logic [THR_BITS-1:0]   AGE_THRESHOLD_RESET   = 24'd150;
   localparam logic [LIMIT_BITS-1:0] MINI_SEND_LIMIT_RESET = 31'd42949672;
   localparam logic [LIMIT_BITS-1:0] DATA_SEND_LIMIT_RESET = 31'd826781204;
   localparam logic [GEN_BITS-1:0]   SEED_START_RESET      = 31'd10101;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AGE_THRESHOLD   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MINI_SEND_LIMIT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DATA_SEND_LIMIT = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEED_START      = 2'd3;

   // request functions
   localparam logic FUNC_ADVANCE = 1'b0;
   localparam logic FUNC_READ    = 1'b1;

   // win phases
   localparam logic [1:0] PHASE_NONE  = 2'd0;
   localparam logic [1:0] PHASE_MINI1 = 2'd1;
   localparam logic [1:0] PHASE_MINI2 = 2'd2;
   localparam logic [1:0] PHASE_DATA  = 2'd3;

   typedef struct packed {
      logic                    func;
      logic [DEV_IDX_BITS-1:0] device_index;
   } aoi_req_type;

   typedef struct packed {
      logic                     winner_valid;
      logic [DEV_IDX_BITS-1:0]  winner_index;
      logic [1:0]               win_phase;
      logic                     data_collision;
      logic [READ_SUM_BITS-1:0] read_sum;
      logic [READ_AGE_BITS-1:0] read_age;
   } aoi_rsp_type;

   // control of the shared generator unit
   typedef struct packed {
      logic                load;
      logic [GEN_BITS-1:0] seed;
      logic                mul;
      logic                commit;
   } aoi_lehmer_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_AGE,
      ST_MINI_CHK,
      ST_MINI_FOLD,
      ST_MINI_END,
      ST_DATA_CHK,
      ST_DATA_FOLD,
      ST_DATA_END,
      ST_OUT
   } aoi_state_type;

endpackage

`default_nettype wire

>>> rtl/core/aoi_lehmer.sv
// ----------------------------------------------------------------------------
// aoi_lehmer
// Lehmer generator, g = g * 16807 mod 2^31-1, multiply then Mersenne fold.
// ----------------------------------------------------------------------------
`default_nettype none

module aoi_lehmer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire aoi_pkg::aoi_lehmer_ctl_type         ctl,
   output logic [aoi_pkg::GEN_BITS-1:0]             draw_val
);

   logic [aoi_pkg::GEN_BITS-1:0]  gen_ff;
   logic [aoi_pkg::PROD_BITS-1:0] prod_ff;
   logic [aoi_pkg::GEN_BITS:0]    fold_sum;

   // product register, one multiply per draw
   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= aoi_pkg::PROD_BITS'(gen_ff) * aoi_pkg::PROD_BITS'(aoi_pkg::LEHMER_MUL);
      end
   end

   // fold high part onto low part, one conditional subtract
   always_comb begin
      fold_sum = (aoi_pkg::GEN_BITS+1)'(prod_ff[aoi_pkg::PROD_BITS-1:aoi_pkg::GEN_BITS])
               + (aoi_pkg::GEN_BITS+1)'(prod_ff[aoi_pkg::GEN_BITS-1:0]);
      if (fold_sum >= (aoi_pkg::GEN_BITS+1)'(aoi_pkg::LEHMER_MOD)) begin
         fold_sum = fold_sum - (aoi_pkg::GEN_BITS+1)'(aoi_pkg::LEHMER_MOD);
      end
      draw_val = fold_sum[aoi_pkg::GEN_BITS-1:0];
   end

   // generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= aoi_pkg::SEED_START_RESET;
      end else if (ctl.load) begin
         gen_ff <= ctl.seed;
      end else if (ctl.commit) begin
         gen_ff <= draw_val;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/aoi_threshold_aloha_contention.sv
// Sequence: a read goes through ST_READ to ST_OUT; an advance ages every device, then
//   runs R passes, R being 1 to 3 (two mini rounds and the data round), with a draw for
//   each eligible device in a pass (in the data round, each eligible flagged device).
// Requests: one at a time, held off by req_stall until the response is taken; each draw
//   goes through the single shared generator, a multiply then a fold.
// Reset: synchronous; ages go to 1, sums to 0, registers and generator to defaults.
// ----------------------------------------------------------------------------
// aoi_threshold_aloha_contention
// Threshold random access with age tracking, walked one device at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module aoi_threshold_aloha_contention #(
   parameter int DEVICES  = aoi_pkg::DEVICES_DEFAULT,
   parameter int AGE_BITS = aoi_pkg::AGE_BITS_DEFAULT,
   parameter int SUM_BITS = aoi_pkg::SUM_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire aoi_pkg::aoi_req_type                req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output aoi_pkg::aoi_rsp_type                     rsp_data,
   input  wire logic                                csr_write,
   input  wire logic [aoi_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [aoi_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int IDX_BITS = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int ADD_BITS = ((SUM_BITS > AGE_BITS) ? SUM_BITS : AGE_BITS) + 1;
   localparam int CMP_BITS = ((AGE_BITS > aoi_pkg::THR_BITS) ? AGE_BITS : aoi_pkg::THR_BITS);
   localparam int SUM_EXT  = (SUM_BITS > aoi_pkg::READ_SUM_BITS) ? SUM_BITS
                                                                 : aoi_pkg::READ_SUM_BITS;
   localparam int AGE_EXT  = (AGE_BITS > aoi_pkg::READ_AGE_BITS) ? AGE_BITS
                                                                 : aoi_pkg::READ_AGE_BITS;

   aoi_pkg::aoi_state_type state_ff, state_in;

   // configuration
   logic [aoi_pkg::THR_BITS-1:0]   thr_ff;
   logic [aoi_pkg::LIMIT_BITS-1:0] mini_lim_ff;
   logic [aoi_pkg::LIMIT_BITS-1:0] data_lim_ff;

   // device state
   logic [AGE_BITS-1:0] age_ff [DEVICES];
   logic [SUM_BITS-1:0] sum_ff [DEVICES];
   logic [DEVICES-1:0]  flag_ff;

   // sequencer registers
   logic [IDX_BITS-1:0] k_ff, k_in;
   logic                round_ff, round_in;
   logic [1:0]          cnt_ff, cnt_in;
   logic [IDX_BITS-1:0] who_ff, who_in;
   logic [IDX_BITS-1:0] best_ff, best_in;
   logic [AGE_BITS-1:0] best_age_ff, best_age_in;
   logic                best_vld_ff, best_vld_in;
   logic                miss_ff, miss_in;
   aoi_pkg::aoi_rsp_type rsp_ff, rsp_in;

   // write controls
   logic                flag_we, flag_val;
   logic                age_we;
   logic [IDX_BITS-1:0] age_widx;
   logic [AGE_BITS-1:0] age_wval;
   logic                sum_we;
   logic [SUM_BITS-1:0] sum_wval;

   // datapath helpers
   logic [AGE_BITS-1:0] age_k;
   logic [SUM_BITS-1:0] sum_k;
   logic [ADD_BITS-1:0] add_sum;
   logic [SUM_EXT-1:0]  sum_ext;
   logic [AGE_EXT-1:0]  age_ext;
   logic                k_last;
   logic                eligible;
   logic                req_accept;
   logic                read_miss;
   logic [aoi_pkg::GEN_BITS-1:0] draw_val;
   logic                mini_hit, data_hit;
   aoi_pkg::aoi_lehmer_ctl_type lehmer_ctl;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != aoi_pkg::ST_IDLE);
   assign rsp_valid  = (state_ff == aoi_pkg::ST_OUT);
   assign rsp_data   = rsp_ff;

   assign age_k    = age_ff[k_ff];
   assign sum_k    = sum_ff[k_ff];
   assign k_last   = (k_ff == IDX_BITS'(DEVICES - 1));
   assign eligible = (CMP_BITS'(age_k) >= CMP_BITS'(thr_ff));
   assign add_sum  = ADD_BITS'(sum_k) + ADD_BITS'(age_k);
   assign sum_ext  = SUM_EXT'(sum_k);
   assign age_ext  = AGE_EXT'(age_k);
   assign read_miss = ({1'b0, req_data.device_index} >= (aoi_pkg::DEV_IDX_BITS+1)'(DEVICES));
   assign mini_hit = (draw_val <= mini_lim_ff);
   assign data_hit = (draw_val <= data_lim_ff);

   // shared generator
   aoi_lehmer u_lehmer (
      .clock    (clock),
      .reset    (reset),
      .ctl      (lehmer_ctl),
      .draw_val (draw_val)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= aoi_pkg::AGE_THRESHOLD_RESET;
         mini_lim_ff <= aoi_pkg::MINI_SEND_LIMIT_RESET;
         data_lim_ff <= aoi_pkg::DATA_SEND_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            aoi_pkg::CSR_AGE_THRESHOLD:   thr_ff      <= csr_wdata[aoi_pkg::THR_BITS-1:0];
            aoi_pkg::CSR_MINI_SEND_LIMIT: mini_lim_ff <= csr_wdata[aoi_pkg::LIMIT_BITS-1:0];
            aoi_pkg::CSR_DATA_SEND_LIMIT: data_lim_ff <= csr_wdata[aoi_pkg::LIMIT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aoi_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_data.func == aoi_pkg::FUNC_READ) ? aoi_pkg::ST_READ
                                                                : aoi_pkg::ST_AGE;
            end
         end
         aoi_pkg::ST_READ: state_in = aoi_pkg::ST_OUT;
         aoi_pkg::ST_AGE: begin
            if (k_last) state_in = aoi_pkg::ST_MINI_CHK;
         end
         aoi_pkg::ST_MINI_CHK: begin
            if (eligible)    state_in = aoi_pkg::ST_MINI_FOLD;
            else if (k_last) state_in = aoi_pkg::ST_MINI_END;
         end
         aoi_pkg::ST_MINI_FOLD: begin
            state_in = k_last ? aoi_pkg::ST_MINI_END : aoi_pkg::ST_MINI_CHK;
         end
         aoi_pkg::ST_MINI_END: begin
            if (cnt_ff == 2'd1)  state_in = aoi_pkg::ST_OUT;
            else if (round_ff)   state_in = aoi_pkg::ST_DATA_CHK;
            else                 state_in = aoi_pkg::ST_MINI_CHK;
         end
         aoi_pkg::ST_DATA_CHK: begin
            if (flag_ff[k_ff] && eligible) state_in = aoi_pkg::ST_DATA_FOLD;
            else if (k_last)               state_in = aoi_pkg::ST_DATA_END;
         end
         aoi_pkg::ST_DATA_FOLD: begin
            state_in = k_last ? aoi_pkg::ST_DATA_END : aoi_pkg::ST_DATA_CHK;
         end
         aoi_pkg::ST_DATA_END: state_in = aoi_pkg::ST_OUT;
         aoi_pkg::ST_OUT: begin
            if (!rsp_stall) state_in = aoi_pkg::ST_IDLE;
         end
         default: state_in = aoi_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath controls
   always_comb begin
      k_in        = k_ff;
      round_in    = round_ff;
      cnt_in      = cnt_ff;
      who_in      = who_ff;
      best_in     = best_ff;
      best_age_in = best_age_ff;
      best_vld_in = best_vld_ff;
      miss_in     = miss_ff;
      rsp_in      = rsp_ff;
      flag_we     = 1'b0;
      flag_val    = 1'b0;
      age_we      = 1'b0;
      age_widx    = k_ff;
      age_wval    = age_k;
      sum_we      = 1'b0;
      sum_wval    = sum_k;
      lehmer_ctl.load   = csr_write && (csr_index == aoi_pkg::CSR_SEED_START);
      lehmer_ctl.seed   = csr_wdata[aoi_pkg::GEN_BITS-1:0];
      lehmer_ctl.mul    = 1'b0;
      lehmer_ctl.commit = 1'b0;
      case (state_ff)
         aoi_pkg::ST_IDLE: begin
            if (req_accept) begin
               rsp_in      = '0;
               round_in    = 1'b0;
               cnt_in      = 2'd0;
               best_vld_in = 1'b0;
               miss_in     = read_miss;
               k_in        = (req_data.func == aoi_pkg::FUNC_READ && !read_miss)
                           ? req_data.device_index[IDX_BITS-1:0] : '0;
            end
         end
         aoi_pkg::ST_READ: begin
            // out-of-range device reads as zero
            if (!miss_ff) begin
               rsp_in.read_sum = sum_ext[aoi_pkg::READ_SUM_BITS-1:0];
               rsp_in.read_age = age_ext[aoi_pkg::READ_AGE_BITS-1:0];
            end
         end
         aoi_pkg::ST_AGE: begin
            // saturating sum, then saturating age increment
            sum_we   = 1'b1;
            sum_wval = (add_sum[ADD_BITS-1:SUM_BITS] != '0) ? '1 : add_sum[SUM_BITS-1:0];
            age_we   = 1'b1;
            age_wval = (age_k == '1) ? age_k : age_k + AGE_BITS'(1);
            k_in     = k_last ? '0 : k_ff + IDX_BITS'(1);
         end
         aoi_pkg::ST_MINI_CHK: begin
            if (eligible) begin
               lehmer_ctl.mul = 1'b1;
            end else begin
               flag_we  = 1'b1;
               flag_val = 1'b0;
               k_in     = k_last ? '0 : k_ff + IDX_BITS'(1);
            end
         end
         aoi_pkg::ST_MINI_FOLD: begin
            lehmer_ctl.commit = 1'b1;
            flag_we  = 1'b1;
            flag_val = mini_hit;
            if (mini_hit) begin
               who_in = k_ff;
               cnt_in = (cnt_ff == 2'd0) ? 2'd1 : 2'd2;
            end
            k_in = k_last ? '0 : k_ff + IDX_BITS'(1);
         end
         aoi_pkg::ST_MINI_END: begin
            // lone sender wins the mini slot
            k_in        = '0;
            cnt_in      = 2'd0;
            round_in    = 1'b1;
            best_vld_in = 1'b0;
            if (cnt_ff == 2'd1) begin
               age_we   = 1'b1;
               age_widx = who_ff;
               age_wval = AGE_BITS'(1);
               rsp_in.winner_valid = 1'b1;
               rsp_in.winner_index = aoi_pkg::DEV_IDX_BITS'(who_ff);
               rsp_in.win_phase    = round_ff ? aoi_pkg::PHASE_MINI2 : aoi_pkg::PHASE_MINI1;
            end
         end
         aoi_pkg::ST_DATA_CHK: begin
            if (flag_ff[k_ff] && eligible) begin
               lehmer_ctl.mul = 1'b1;
            end else begin
               k_in = k_last ? '0 : k_ff + IDX_BITS'(1);
            end
         end
         aoi_pkg::ST_DATA_FOLD: begin
            // oldest sender wins, lowest index on ties
            lehmer_ctl.commit = 1'b1;
            if (data_hit) begin
               cnt_in = (cnt_ff == 2'd0) ? 2'd1 : 2'd2;
               if (!best_vld_ff || age_k > best_age_ff) begin
                  best_in     = k_ff;
                  best_age_in = age_k;
                  best_vld_in = 1'b1;
               end
            end
            k_in = k_last ? '0 : k_ff + IDX_BITS'(1);
         end
         aoi_pkg::ST_DATA_END: begin
            // empty data slot leaves everything alone
            if (best_vld_ff) begin
               age_we   = 1'b1;
               age_widx = best_ff;
               age_wval = AGE_BITS'(1);
               rsp_in.winner_valid   = 1'b1;
               rsp_in.winner_index   = aoi_pkg::DEV_IDX_BITS'(best_ff);
               rsp_in.win_phase      = aoi_pkg::PHASE_DATA;
               rsp_in.data_collision = (cnt_ff == 2'd2);
            end
         end
         aoi_pkg::ST_OUT: ;
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= aoi_pkg::ST_IDLE;
         k_ff        <= '0;
         round_ff    <= 1'b0;
         cnt_ff      <= 2'd0;
         best_vld_ff <= 1'b0;
         miss_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         round_ff    <= round_in;
         cnt_ff      <= cnt_in;
         best_vld_ff <= best_vld_in;
         miss_ff     <= miss_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      who_ff      <= who_in;
      best_ff     <= best_in;
      best_age_ff <= best_age_in;
      rsp_ff      <= rsp_in;
      if (flag_we) begin
         flag_ff[k_ff] <= flag_val;
      end
   end

   // per-device age and sum
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEVICES; i++) begin
            age_ff[i] <= AGE_BITS'(1);
            sum_ff[i] <= '0;
         end
      end else begin
         if (age_we) begin
            age_ff[age_widx] <= age_wval;
         end
         if (sum_we) begin
            sum_ff[k_ff] <= sum_wval;
         end
      end
   end

   // checks
   a_collision_in_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.data_collision) |->
         (rsp_data.winner_valid && rsp_data.win_phase == aoi_pkg::PHASE_DATA))
      else $error("collision reported outside a data slot win");

   a_no_winner_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.winner_valid) |->
         (rsp_data.win_phase == aoi_pkg::PHASE_NONE && rsp_data.winner_index == '0))
      else $error("winner fields set without a winner");

   a_read_no_winner: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.read_age != '0) |-> !rsp_data.winner_valid)
      else $error("read response carries winner fields");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != aoi_pkg::ST_IDLE))
      else $error("sequencer idle right after accepting a request");

endmodule

`default_nettype wire
